@@ sv/count_non_multiples_sieve_macros.svh @@
// Assertion macros used by the sieve block to check itself.
`ifndef COUNT_NON_MULTIPLES_SIEVE_MACROS_SVH
`define COUNT_NON_MULTIPLES_SIEVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cnms assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cnms assertion failed");

`endif

@@ sv/cnms_pkg.sv @@
`default_nettype none
package cnms_pkg;

    localparam int DW  = 21;
    localparam int KW  = DW + 1;
    localparam int PAW = 3;
    localparam int PDW = 32;

    localparam logic [0:0]    REG_UPPER_LIMIT   = 1'b0;
    localparam logic [DW-1:0] UPPER_LIMIT_RESET = DW'(1);

    typedef struct packed {
        logic [DW-1:0] upper_limit;
    } t_cfg;

endpackage
`default_nettype wire

@@ sv/count_non_multiples_sieve.sv @@
// Counts the integers from 1 to upper_limit (capped at MAX_LIMIT) that no divisor word of a
// job divides. Each divisor word d walks its multiples through a one-bit-per-integer bitmap
// RAM, one read-modify-write per cycle; a zero divisor or one above the limit marks nothing.
// After the word flagged last the result is posted once an earlier result has been taken,
// then a clearing pass runs over as many entries as the largest limit used in that job,
// during which no divisor is taken. After reset a clearing pass over all MAX_LIMIT entries
// runs before the first divisor is taken; configuration writes are taken at any time.
`default_nettype none
`include "count_non_multiples_sieve_macros.svh"
module count_non_multiples_sieve #(
    parameter int MAX_LIMIT = 1048576
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cnms_pkg::PAW-1:0]  paddr,
    input  wire logic [cnms_pkg::PDW-1:0]  pwdata,
    output      logic [cnms_pkg::PDW-1:0]  prdata,
    output      logic                      pready,
    input  wire logic                      i_div_valid,
    output      logic                      o_div_ready,
    input  wire logic [cnms_pkg::DW-1:0]   i_divisor,
    input  wire logic                      i_last_divisor,
    output      logic                      o_res_valid,
    input  wire logic                      i_res_ready,
    output      logic [cnms_pkg::DW-1:0]   o_free_count
);
    import cnms_pkg::*;

    localparam int AW = $clog2(MAX_LIMIT);
    localparam int WW = (AW > KW) ? AW : KW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;

    t_cfg w_cfg;

    logic [2:0]    r_state, n_state;
    logic [DW-1:0] r_total, n_total;
    logic [DW-1:0] r_hi, n_hi;
    logic          r_res_valid, n_res_valid;
    logic          r_rd_valid, n_rd_valid;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_clr_end, n_clr_end;
    logic [KW-1:0] r_k, n_k;
    logic [DW-1:0] r_d, n_d;
    logic          r_last, n_last;
    logic [AW-1:0] r_rd_addr;
    logic [DW-1:0] r_free;

    logic [DW-1:0] w_lim;
    logic          w_issue;
    logic [WW-1:0] w_pos;
    logic [WW-1:0] w_hi_m1;
    logic [AW-1:0] w_raddr;
    logic [0:0]    w_rdata;
    logic          w_mark;
    logic          w_load;
    logic [DW-1:0] w_result;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [0:0]    w_wdata;

    cnms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_lim = (32'(w_cfg.upper_limit) > 32'(MAX_LIMIT)) ? DW'(MAX_LIMIT)
                                                             : w_cfg.upper_limit;

    assign w_issue  = (r_state == ST_WALK) && (r_k <= {1'b0, w_lim});
    assign w_pos    = WW'(r_k - 1'b1);
    assign w_raddr  = w_pos[AW-1:0];
    assign w_hi_m1  = WW'(r_hi - 1'b1);
    assign w_mark   = r_rd_valid && !w_rdata[0];
    assign w_load   = (r_state == ST_FINISH) && (!r_res_valid || i_res_ready);
    assign w_result = (w_lim > r_total) ? (w_lim - r_total) : '0;

    assign w_we    = (r_state == ST_CLEAR) || w_mark;
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_rd_addr;
    assign w_wdata = (r_state == ST_CLEAR) ? 1'b0 : 1'b1;

    cnms_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LIMIT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_hi        = r_hi;
        n_res_valid = r_res_valid;
        n_rd_valid  = w_issue;
        n_clr_addr  = r_clr_addr;
        n_clr_end   = r_clr_end;
        n_k         = r_k;
        n_d         = r_d;
        n_last      = r_last;
        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end
        if (w_mark) begin
            n_total = r_total + 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_div_valid) begin
                    n_state = ST_WALK;
                    n_k     = (i_divisor == '0) ? '1 : {1'b0, i_divisor};
                    n_d     = i_divisor;
                    n_last  = i_last_divisor;
                    if (w_lim > r_hi) begin
                        n_hi = w_lim;
                    end
                end
            end
            ST_WALK: begin
                if (w_issue) begin
                    n_k = r_k + {1'b0, r_d};
                end else begin
                    n_state = r_last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (w_load) begin
                    n_res_valid = 1'b1;
                    n_total     = '0;
                    n_hi        = '0;
                    if (r_hi != '0) begin
                        n_state    = ST_CLEAR;
                        n_clr_addr = '0;
                        n_clr_end  = w_hi_m1[AW-1:0];
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == r_clr_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_total     <= '0;
            r_hi        <= '0;
            r_res_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_end   <= AW'(MAX_LIMIT - 1);
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_hi        <= n_hi;
            r_res_valid <= n_res_valid;
            r_rd_valid  <= n_rd_valid;
            r_clr_addr  <= n_clr_addr;
            r_clr_end   <= n_clr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_d       <= n_d;
        r_last    <= n_last;
        r_rd_addr <= w_raddr;
        if (w_load) begin
            r_free <= w_result;
        end
    end

    assign o_div_ready  = (r_state == ST_IDLE);
    assign o_res_valid  = r_res_valid;
    assign o_free_count = r_free;

    `CNMS_ASSERT_SAME(a_mark_follows_walk, i_clk, i_rst_n, r_rd_valid, $past(r_state) == ST_WALK)
    `CNMS_ASSERT_SAME(a_no_read_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !r_rd_valid)
    `CNMS_ASSERT_NEXT(a_load_resets_total, i_clk, i_rst_n, w_load, (r_total == '0) && r_res_valid)

endmodule
`default_nettype wire

@@ sv/cnms_ram.sv @@
`default_nettype none
module cnms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/cnms_regs.sv @@
`default_nettype none
module cnms_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cnms_pkg::PAW-1:0]  paddr,
    input  wire logic [cnms_pkg::PDW-1:0]  pwdata,
    output      logic [cnms_pkg::PDW-1:0]  prdata,
    output      logic                      pready,
    output      cnms_pkg::t_cfg            o_cfg
);
    import cnms_pkg::*;

    t_cfg r_cfg;
    logic w_sel_limit;
    logic w_write;

    assign pready      = 1'b1;
    assign w_sel_limit = (paddr[PAW-1:PAW-1] == REG_UPPER_LIMIT);
    assign w_write     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_limit <= UPPER_LIMIT_RESET;
        end else if (w_write && w_sel_limit) begin
            r_cfg.upper_limit <= pwdata[DW-1:0];
        end
    end

    assign prdata = w_sel_limit ? PDW'(r_cfg.upper_limit) : '0;
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire
